[sv/assert_macros.svh]
// assertion macros used by the checker file dtc_checker
// no dependencies; expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DTC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("dtc assertion failed");

// next-cycle implication, disabled during reset
`define DTC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error("dtc assertion failed");

`endif

[sv/dtc_pkg.sv]
// shared constants and types of the domino tiling counter
// no dependencies
package dtc_pkg;

	localparam int MAX_WIDTH_DEF  = 12;
	localparam int MAX_HEIGHT_DEF = 12;
	localparam int DIM_W          = 4;
	localparam int COUNT_W        = 56;

	// engine to row memory control
	typedef struct packed {
		logic wr_en;
		logic rd_bank;
	} mem_ctl_t;

endpackage

[sv/dtc_row_mem.sv]
// one bank of row counts, one write and one registered read port
// depends on nothing but its parameters
module dtc_row_mem #(
	parameter int AW = 12,
	parameter int DW = 56
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/dtc_compat.sv]
// two-stage check that one row profile may follow another
// depends on nothing but its parameters
module dtc_compat #(
	parameter int PW = 12
) (
	input  logic          clk,
	input  logic [PW-1:0] prev,
	input  logic [PW-1:0] cur,
	input  logic [PW-1:0] full,
	output logic          ok_s1
);

	localparam int LO = (PW + 1) / 2;

	logic [PW-1:0] x;
	logic          pend_lo;
	logic          fail_lo;
	logic          orok;

	logic [PW-1:0] x_s1;
	logic          pend_s1;
	logic          fail_s1;
	logic          orok_s1;

	logic          pend_hi;
	logic          fail_hi;

	// lower half of the run-parity scan
	always_comb begin
		x       = prev & cur;
		orok    = ((prev | cur) & full) == full;
		pend_lo = 1'b0;
		fail_lo = 1'b0;
		for (int k = 0; k < LO; k++) begin
			if (x[k]) begin
				pend_lo = ~pend_lo;
			end else begin
				if (pend_lo) fail_lo = 1'b1;
				pend_lo = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x;
		pend_s1 <= pend_lo;
		fail_s1 <= fail_lo;
		orok_s1 <= orok;
	end

	// upper half
	always_comb begin
		pend_hi = pend_s1;
		fail_hi = fail_s1;
		for (int k = LO; k < PW; k++) begin
			if (x_s1[k]) begin
				pend_hi = ~pend_hi;
			end else begin
				if (pend_hi) fail_hi = 1'b1;
				pend_hi = 1'b0;
			end
		end
	end

	assign ok_s1 = orok_s1 && !fail_hi && !pend_hi;

endmodule

[sv/dtc_engine.sv]
// row sequencer and accumulator of the profile dynamic programme
// depends on dtc_pkg and dtc_compat
module dtc_engine #(
	parameter int MAX_WIDTH  = dtc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dtc_pkg::MAX_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dtc_pkg::DIM_W-1:0]    board_width,
	input  logic [dtc_pkg::DIM_W-1:0]    board_height,
	output logic                         res_valid,
	input  logic                         res_take,
	output logic [dtc_pkg::COUNT_W-1:0]  result,
	output logic [MAX_WIDTH-1:0]         rd_addr,
	input  logic [dtc_pkg::COUNT_W-1:0]  rd_data,
	output logic [MAX_WIDTH-1:0]         wr_addr,
	output logic [dtc_pkg::COUNT_W-1:0]  wr_data,
	output dtc_pkg::mem_ctl_t            mem_ctl
);

	localparam int PW = MAX_WIDTH;
	localparam int DW = dtc_pkg::DIM_W;
	localparam int CW = dtc_pkg::COUNT_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]    state_q;
	logic [PW-1:0] full_q;
	logic [DW-1:0] last_row_q;
	logic [DW-1:0] row_q;
	logic [PW-1:0] c_q;
	logic [PW-1:0] p_q;
	logic          bank_q;
	logic [CW-1:0] acc_q;
	logic [CW-1:0] result_q;

	logic          vld_s1;
	logic          last_s1;
	logic          first_s1;
	logic [PW-1:0] c_s1;
	logic          ok_s1;

	logic          dims_ok;
	logic [PW-1:0] full_d;
	logic          p_last;
	logic          c_last;
	logic [CW-1:0] addend;
	logic [CW-1:0] sum;

	assign dims_ok = board_width  >= DW'(1) && board_width  <= DW'(MAX_WIDTH) &&
	                 board_height >= DW'(1) && board_height <= DW'(MAX_HEIGHT);

	always_comb begin
		for (int k = 0; k < PW; k++) begin
			full_d[k] = DW'(k) < board_width;
		end
	end

	assign p_last = p_q == full_q;
	assign c_last = c_q == full_q;

	dtc_compat #(.PW(PW)) u_compat (
		.clk   (clk),
		.prev  (p_q),
		.cur   (c_q),
		.full  (full_q),
		.ok_s1 (ok_s1)
	);

	// the first row follows an all-ones profile of count one
	always_comb begin
		if (!ok_s1) begin
			addend = '0;
		end else if (first_s1) begin
			addend = last_s1 ? CW'(1) : '0;
		end else begin
			addend = rd_data;
		end
		sum = acc_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			acc_q   <= '0;
			bank_q  <= 1'b0;
		end else begin
			vld_s1 <= state_q == ST_RUN;
			if (vld_s1) begin
				acc_q <= last_s1 ? '0 : sum;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= dims_ok ? ST_RUN : ST_DONE;
						bank_q  <= 1'b0;
					end
				end
				ST_RUN: begin
					if (p_last && c_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!vld_s1) begin
						if (row_q == last_row_q) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RUN;
							bank_q  <= ~bank_q;
						end
					end
				end
				ST_DONE: begin
					if (res_take) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= row_q == '0;
		last_s1  <= p_last;
		c_s1     <= c_q;
		if (vld_s1 && last_s1 && c_s1 == full_q) begin
			result_q <= sum;
		end
		unique case (state_q)
			ST_IDLE: begin
				full_q     <= full_d;
				last_row_q <= board_height - DW'(1);
				row_q      <= '0;
				c_q        <= '0;
				p_q        <= '0;
				if (in_valid && !dims_ok) result_q <= '0;
			end
			ST_RUN: begin
				if (p_last) begin
					p_q <= '0;
					if (!c_last) c_q <= c_q + PW'(1);
				end else begin
					p_q <= p_q + PW'(1);
				end
			end
			ST_DRAIN: begin
				if (!vld_s1 && row_q != last_row_q) begin
					row_q <= row_q + DW'(1);
					c_q   <= '0;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign in_ready        = state_q == ST_IDLE;
	assign res_valid       = state_q == ST_DONE;
	assign result          = result_q;
	assign rd_addr         = p_q;
	assign wr_addr         = c_s1;
	assign wr_data         = sum;
	assign mem_ctl.wr_en   = vld_s1 && last_s1;
	assign mem_ctl.rd_bank = bank_q;

endmodule

[sv/domino_tiling_counter_top.sv]
// domino tiling counter: top level with ping-pong row banks and output word register
// depends on dtc_pkg, dtc_engine and dtc_row_mem
//
//   channel | handshake            | word
//   in      | in_valid / in_ready  | board_width, board_height
//   out     | out_valid / out_ready| tiling_count
//
// for a board of width w and height h, every pair of previous and current
// profiles is checked once per row, one pair a cycle while a row runs, at the
// single read port of the bank holding the previous row; out-of-range
// dimensions answer 0
// reset is asynchronous, active low, and needs no clearing pass: every entry read
// is written in the row before
// a new word is taken while the previous result waits in the output register
module domino_tiling_counter_top #(
	parameter int MAX_WIDTH  = dtc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = dtc_pkg::MAX_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dtc_pkg::DIM_W-1:0]    board_width,
	input  logic [dtc_pkg::DIM_W-1:0]    board_height,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dtc_pkg::COUNT_W-1:0]  tiling_count
);

	localparam int CW = dtc_pkg::COUNT_W;

	logic                 res_valid;
	logic                 res_take;
	logic [CW-1:0]        result;
	logic [MAX_WIDTH-1:0] rd_addr;
	logic [MAX_WIDTH-1:0] wr_addr;
	logic [CW-1:0]        wr_data;
	logic [CW-1:0]        rdata0;
	logic [CW-1:0]        rdata1;
	dtc_pkg::mem_ctl_t    mem_ctl;

	logic                 out_valid_q;
	logic [CW-1:0]        count_q;

	dtc_engine #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.board_width  (board_width),
		.board_height (board_height),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.result       (result),
		.rd_addr      (rd_addr),
		.rd_data      (mem_ctl.rd_bank ? rdata1 : rdata0),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.mem_ctl      (mem_ctl)
	);

	// read one bank, write the other
	dtc_row_mem #(.AW(MAX_WIDTH), .DW(CW)) u_bank0 (
		.clk   (clk),
		.we    (mem_ctl.wr_en && mem_ctl.rd_bank),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rdata0)
	);

	dtc_row_mem #(.AW(MAX_WIDTH), .DW(CW)) u_bank1 (
		.clk   (clk),
		.we    (mem_ctl.wr_en && !mem_ctl.rd_bank),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rdata1)
	);

	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) count_q <= result;
	end

	assign out_valid    = out_valid_q;
	assign tiling_count = count_q;

endmodule

[sv/dtc_checker.sv]
// port-level checks on the domino tiling counter, bound to the top level
// depends on dtc_pkg and assert_macros.svh
`include "assert_macros.svh"

module dtc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [dtc_pkg::DIM_W-1:0]    board_width,
	input logic [dtc_pkg::DIM_W-1:0]    board_height,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [dtc_pkg::COUNT_W-1:0]  tiling_count
);

	// a waiting result word holds
	`DTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(tiling_count))

	// one word in work at a time
	`DTC_ASSERT_NEXT(a_single_word, in_valid && in_ready, !in_ready)

	// an empty board answers zero, through the engine result register and then the output word register
	`DTC_ASSERT_NEXT(a_empty_board, in_valid && in_ready && !out_valid && (board_width == 4'd0 || board_height == 4'd0), ##1 (out_valid && tiling_count == '0))

	// the engine is free again once its result is registered
	`DTC_ASSERT_IMPL(a_free_on_result, $rose(out_valid), in_ready)

endmodule

bind domino_tiling_counter_top dtc_checker u_dtc_checker (.*);

[tb/tb_domino_tiling_counter_top.sv]
// self-checking testbench for domino_tiling_counter_top: directed and random boards,
// with tiling counts predicted by a row-profile count held in a small checker class
// depends on dtc_pkg and domino_tiling_counter_top
module tb_domino_tiling_counter_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WIDTH_DEF  = dtc_pkg::MAX_WIDTH_DEF;
	localparam int MAX_HEIGHT_DEF = dtc_pkg::MAX_HEIGHT_DEF;
	localparam int DIM_W          = dtc_pkg::DIM_W;
	localparam int COUNT_W        = dtc_pkg::COUNT_W;

	localparam int PROFILES    = 1 << MAX_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 30_000_000;
	localparam int RANDOM_BOARDS = 77;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_PULSED
	} rx_mode_t;

	class tiling_checker_t;
		bit [63:0]        prev_row [0:PROFILES-1];
		bit [63:0]        cur_row  [0:PROFILES-1];
		bit [COUNT_W-1:0] expected_counts [$];
		int unsigned      checked;
		int unsigned      mismatches;

		// extends a row profile cell by cell after the profile prev
		function void spread_profile(int unsigned prev, int unsigned width,
				int unsigned pos, int unsigned partial, bit [63:0] weight);
			int unsigned pos_mask;
			if (pos >= width) begin
				cur_row[partial[MAX_WIDTH_DEF-1:0]] += weight;
				return;
			end
			pos_mask = 1 << pos;
			if ((prev & pos_mask) == 0) begin
				spread_profile(prev, width, pos + 1, partial | pos_mask, weight);
				return;
			end
			spread_profile(prev, width, pos + 1, partial, weight);
			if (pos + 1 < width && (prev & (pos_mask << 1)) != 0)
				spread_profile(prev, width, pos + 2, partial | pos_mask | (pos_mask << 1),
					weight);
		endfunction

		function bit [COUNT_W-1:0] count_tilings(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
			int unsigned width;
			int unsigned height;
			int unsigned full;
			width  = 32'(w);
			height = 32'(h);
			if (width < 1 || width > MAX_WIDTH_DEF || height < 1 || height > MAX_HEIGHT_DEF)
				return '0;
			full = (1 << width) - 1;
			foreach (prev_row[i])
				prev_row[i] = '0;
			prev_row[full[MAX_WIDTH_DEF-1:0]] = 64'd1;
			for (int unsigned r = 0; r < height; r++) begin
				foreach (cur_row[i])
					cur_row[i] = '0;
				for (int unsigned p = 0; p <= full; p++)
					if (prev_row[p[MAX_WIDTH_DEF-1:0]] != 0)
						spread_profile(p, width, 0, 0, prev_row[p[MAX_WIDTH_DEF-1:0]]);
				prev_row = cur_row;
			end
			return prev_row[full[MAX_WIDTH_DEF-1:0]][COUNT_W-1:0];
		endfunction

		function void note_board(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
			expected_counts = {expected_counts, count_tilings(w, h)};
		endfunction

		task report_mismatch(string what);
			$display("%0t mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		task check_count(logic [COUNT_W-1:0] got);
			bit [COUNT_W-1:0] want;
			if (expected_counts.size() == 0) begin
				report_mismatch($sformatf("tiling_count %0d with no word pending", got));
				return;
			end
			want = expected_counts.pop_front();
			checked++;
			if (got !== want)
				report_mismatch($sformatf("tiling_count got %0d, want %0d", got, want));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [DIM_W-1:0]    board_width = '0;
	logic [DIM_W-1:0]    board_height = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [COUNT_W-1:0]  tiling_count;

	tiling_checker_t tiling_chk = new;
	int unsigned   cycles;
	int unsigned   boards_sent;
	int unsigned   bad_boards_sent;
	int unsigned   burst_left;
	rx_mode_t      rx_mode = RX_OPEN;
	int unsigned   rx_left;
	int unsigned   rx_tick;

	domino_tiling_counter_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.board_width  (board_width),
		.board_height (board_height),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.tiling_count (tiling_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver stall pattern
	always @(negedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_left <= $urandom_range(50, 400);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
			default:   out_ready <= (rx_tick[4:0] >= 5'd24);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tiling_chk.check_count(tiling_count);
	end

	task automatic pause_sender(int unsigned n);
		@(negedge clk);
		in_valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic pace_sender();
		if (burst_left == 0) begin
			pause_sender($urandom_range(1, 20));
			burst_left = $urandom_range(1, 8);
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_board(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
		@(negedge clk);
		in_valid     = 1'b1;
		board_width  = w;
		board_height = h;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tiling_chk.note_board(w, h);
		boards_sent++;
		if (w < 1 || w > MAX_WIDTH_DEF || h < 1 || h > MAX_HEIGHT_DEF)
			bad_boards_sent++;
		pace_sender();
	endtask

	initial begin
		int unsigned dir_w [] = '{1, 2, 1, 2, 3, 4, 1, 2, 3, 6, 7, 8, 5, 0, 5, 0, 15, 13,
			2, 14, 1, 12, 4};
		int unsigned dir_h [] = '{1, 1, 2, 2, 2, 4, 12, 12, 12, 12, 7, 2, 5, 5, 0, 0, 15, 2,
			13, 1, 14, 0, 9};
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		int unsigned kind;
		int unsigned bad;

		burst_left = $urandom_range(1, 8);
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_w[i])
			send_board(DIM_W'(dir_w[i]), DIM_W'(dir_h[i]));

		for (int i = 0; i < RANDOM_BOARDS; i++) begin
			kind = $urandom_range(0, 9);
			w = DIM_W'($urandom_range(1, 5));
			h = DIM_W'($urandom_range(1, MAX_HEIGHT_DEF));
			if (kind == 0) begin
				bad = $urandom_range(12, 15);
				if (bad == 12)
					bad = 0;
				if ($urandom_range(0, 1))
					w = DIM_W'(bad);
				else
					h = DIM_W'(bad);
			end else if (kind == 1) begin
				w = DIM_W'(6);
			end
			send_board(w, h);
		end
		pause_sender(1);

		while (tiling_chk.expected_counts.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d boards sent (%0d out of range), %0d counts checked, %0d mismatches",
			boards_sent, bad_boards_sent, tiling_chk.checked, tiling_chk.mismatches);
		$display("sender bursts and receiver stalls mixed throughout, %0d cycles", cycles);
		if (tiling_chk.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
